// ===== rtl/cfu_pkg.sv =====
`timescale 1ns / 1ps

package cfu_pkg;

    // face codes
    localparam logic [2:0] FACE_PX = 3'd0;
    localparam logic [2:0] FACE_NX = 3'd1;
    localparam logic [2:0] FACE_PY = 3'd2;
    localparam logic [2:0] FACE_NY = 3'd3;
    localparam logic [2:0] FACE_PZ = 3'd4;
    localparam logic [2:0] FACE_NZ = 3'd5;

    // axis codes
    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // control that travels along the divider row
    typedef struct packed {
        logic       valid;
        logic [2:0] face;
    } t_ctl;

    typedef struct packed {
        logic [1:0] major;
        logic [1:0] u_axis;
        logic       u_neg;
        logic [1:0] v_axis;
        logic       v_neg;
        logic       pos;
    } t_face_desc;

    function automatic t_face_desc face_desc(input logic [2:0] face);
        t_face_desc d;
        case (face)
            FACE_PX: d = '{AXIS_X, AXIS_Z, 1'b1, AXIS_Y, 1'b1, 1'b1};
            FACE_NX: d = '{AXIS_X, AXIS_Z, 1'b0, AXIS_Y, 1'b1, 1'b0};
            FACE_PY: d = '{AXIS_Y, AXIS_X, 1'b0, AXIS_Z, 1'b0, 1'b1};
            FACE_NY: d = '{AXIS_Y, AXIS_X, 1'b0, AXIS_Z, 1'b1, 1'b0};
            FACE_PZ: d = '{AXIS_Z, AXIS_X, 1'b0, AXIS_Y, 1'b1, 1'b1};
            FACE_NZ: d = '{AXIS_Z, AXIS_X, 1'b1, AXIS_Y, 1'b1, 1'b0};
            default: d = '{AXIS_Z, AXIS_X, 1'b1, AXIS_Y, 1'b1, 1'b0};
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/cfu_if.sv =====
`timescale 1ns / 1ps

interface cfu_in_if #(
    parameter int COMPONENT_WIDTH = 16
);
    logic                              valid;
    logic                              ready;
    logic                              func;
    logic [2:0]                        face_in;
    logic signed [COMPONENT_WIDTH-1:0] dir_x;
    logic signed [COMPONENT_WIDTH-1:0] dir_y;
    logic signed [COMPONENT_WIDTH-1:0] dir_z;

    modport source (output valid, func, face_in, dir_x, dir_y, dir_z, input ready);
    modport sink (input valid, func, face_in, dir_x, dir_y, dir_z, output ready);
endinterface

interface cfu_out_if #(
    parameter int FRACTION_BITS = 15
);
    logic                   valid;
    logic                   ready;
    logic [2:0]             face_out;
    logic [FRACTION_BITS:0] u_coord;
    logic [FRACTION_BITS:0] v_coord;

    modport source (output valid, face_out, u_coord, v_coord, input ready);
    modport sink (input valid, face_out, u_coord, v_coord, output ready);
endinterface

// ===== rtl/cfu_front.sv =====
`timescale 1ns / 1ps

module cfu_front #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int FRACTION_BITS   = 15
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    cfu_in_if.sink                           i_req,
    input  logic                             i_ready,
    output cfu_pkg::t_ctl                    o_ctl,
    output logic [1:0][COMPONENT_WIDTH:0]    o_rem,
    output logic [1:0][COMPONENT_WIDTH:0]    o_div,
    output logic [1:0][FRACTION_BITS:0]      o_quo
);
    import cfu_pkg::*;

    localparam int CW = COMPONENT_WIDTH;
    localparam int RW = COMPONENT_WIDTH + 1;

    logic signed [CW-1:0] c [3];
    logic [CW-1:0]        a [3];
    logic [2:0]           pick;
    logic [2:0]           face;
    t_face_desc           fd;
    logic                 bad;
    logic [CW-1:0]        am;
    logic [CW-1:0]        al [2];
    logic signed [CW-1:0] cm;
    logic signed [CW-1:0] cl [2];
    logic                 lneg [2];
    logic                 opp;
    logic                 u_big;
    logic [1:0][RW-1:0]   n_rem;
    logic [1:0][RW-1:0]   n_div;
    logic                 adv;
    logic                 r_valid;
    logic [2:0]           r_face;
    logic [1:0][RW-1:0]   r_rem;
    logic [1:0][RW-1:0]   r_div;

    assign c[0] = i_req.dir_x;
    assign c[1] = i_req.dir_y;
    assign c[2] = i_req.dir_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            a[i] = c[i][CW-1] ? CW'(-c[i]) : CW'(c[i]);
        end
    end

    // major axis, ties go to z
    always_comb begin
        if (a[0] > a[1] && a[0] > a[2]) begin
            pick = (c[0] > 0) ? FACE_PX : FACE_NX;
        end else if (a[1] > a[0] && a[1] > a[2]) begin
            pick = (c[1] > 0) ? FACE_PY : FACE_NY;
        end else begin
            pick = (c[2] > 0) ? FACE_PZ : FACE_NZ;
        end
    end

    assign face  = i_req.func ? pick : i_req.face_in;
    assign bad   = face > FACE_NZ;
    assign fd    = face_desc(face);
    assign am    = a[fd.major];
    assign cm    = c[fd.major];
    assign al[0] = a[fd.u_axis];
    assign al[1] = a[fd.v_axis];
    assign cl[0] = c[fd.u_axis];
    assign cl[1] = c[fd.v_axis];
    assign lneg[0] = fd.u_neg;
    assign lneg[1] = fd.v_neg;
    assign opp   = (fd.pos ? (cm < 0) : (cm > 0)) && (am > al[0]) && (am > al[1]);
    assign u_big = al[0] > al[1];

    // numerator+denominator and twice the denominator for each coordinate
    always_comb begin
        logic signed [CW+1:0] sc;
        logic signed [CW+1:0] nq;
        logic                 forced;
        logic                 fpos;
        for (int l = 0; l < 2; l++) begin
            sc     = lneg[l] ? -(CW+2)'(cl[l]) : (CW+2)'(cl[l]);
            nq     = $signed({2'b00, am}) + sc;
            forced = opp && ((l == 0) ? u_big : !u_big);
            fpos   = lneg[l] ? (cl[l] < 0) : (cl[l] > 0);
            if (bad) begin
                n_rem[l] = RW'(1);
                n_div[l] = RW'(2);
            end else if (am <= al[l]) begin
                n_rem[l] = ((cl[l] > 0) ^ lneg[l]) ? RW'(2) : RW'(0);
                n_div[l] = RW'(2);
            end else if (forced) begin
                n_rem[l] = fpos ? RW'(2) : RW'(0);
                n_div[l] = RW'(2);
            end else begin
                n_rem[l] = nq[RW-1:0];
                n_div[l] = {am, 1'b0};
            end
        end
    end

    assign adv         = !r_valid || i_ready;
    assign i_req.ready = adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (adv) begin
            r_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_face <= face;
            r_rem  <= n_rem;
            r_div  <= n_div;
        end
    end

    assign o_ctl = '{valid: r_valid, face: r_face};
    assign o_rem = r_rem;
    assign o_div = r_div;
    assign o_quo = '0;

endmodule

// ===== rtl/cfu_cell.sv =====
`timescale 1ns / 1ps

module cfu_cell #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int FRACTION_BITS   = 15,
    parameter int BIT             = 15
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  cfu_pkg::t_ctl                 i_ctl,
    input  logic [1:0][COMPONENT_WIDTH:0] i_rem,
    input  logic [1:0][COMPONENT_WIDTH:0] i_div,
    input  logic [1:0][FRACTION_BITS:0]   i_quo,
    output logic                          o_ready,
    input  logic                          i_ready,
    output cfu_pkg::t_ctl                 o_ctl,
    output logic [1:0][COMPONENT_WIDTH:0] o_rem,
    output logic [1:0][COMPONENT_WIDTH:0] o_div,
    output logic [1:0][FRACTION_BITS:0]   o_quo
);
    import cfu_pkg::*;

    localparam int RW = COMPONENT_WIDTH + 1;

    logic [1:0][RW-1:0]            n_rem;
    logic [1:0][FRACTION_BITS:0]   n_quo;
    logic                          r_valid;
    logic [2:0]                    r_face;
    logic [1:0][RW-1:0]            r_rem;
    logic [1:0][RW-1:0]            r_div;
    logic [1:0][FRACTION_BITS:0]   r_quo;

    // one restoring step per lane, the top cell takes the remainder unshifted
    always_comb begin
        logic [RW:0] sh;
        logic [RW:0] df;
        for (int l = 0; l < 2; l++) begin
            sh = (BIT == FRACTION_BITS) ? {1'b0, i_rem[l]} : {i_rem[l], 1'b0};
            df = sh - {1'b0, i_div[l]};
            n_quo[l] = i_quo[l];
            if (sh >= {1'b0, i_div[l]}) begin
                n_rem[l]      = df[RW-1:0];
                n_quo[l][BIT] = 1'b1;
            end else begin
                n_rem[l] = sh[RW-1:0];
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready) begin
            r_face <= i_ctl.face;
            r_rem  <= n_rem;
            r_div  <= i_div;
            r_quo  <= n_quo;
        end
    end

    assign o_ctl = '{valid: r_valid, face: r_face};
    assign o_rem = r_rem;
    assign o_div = r_div;
    assign o_quo = r_quo;

endmodule

// ===== rtl/cube_face_and_uv_from_direction_top.sv =====
`timescale 1ns / 1ps

// a request is registered in the front, then in each divider cell in turn
// throughput: one request per cycle when not stalled, one quotient bit per cell
// the row of cells stalls only where it is full, so bubbles are squeezed out
// reset: synchronous active-low i_rst_n clears every stage valid, no data held

module cube_face_and_uv_from_direction_top #(
    parameter int COMPONENT_WIDTH = 16,
    parameter int FRACTION_BITS   = 15
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    cfu_in_if.sink    i_req,
    cfu_out_if.source o_rsp
);
    import cfu_pkg::*;

    localparam int RW    = COMPONENT_WIDTH + 1;
    localparam int NCELL = FRACTION_BITS + 1;

    // stage k is fed by the front (k = 0) or by cell k-1
    t_ctl                        s_ctl [NCELL+1];
    logic [1:0][RW-1:0]          s_rem [NCELL+1];
    logic [1:0][RW-1:0]          s_div [NCELL+1];
    logic [1:0][FRACTION_BITS:0] s_quo [NCELL+1];
    logic                        s_rdy [NCELL+1];

    // face pick, edge and opposite-face handling, divider operand setup
    cfu_front #(
        .COMPONENT_WIDTH (COMPONENT_WIDTH),
        .FRACTION_BITS   (FRACTION_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_ready (s_rdy[0]),
        .o_ctl   (s_ctl[0]),
        .o_rem   (s_rem[0]),
        .o_div   (s_div[0]),
        .o_quo   (s_quo[0])
    );

    // divider row, msb of the quotient first, both coordinates side by side
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        cfu_cell #(
            .COMPONENT_WIDTH (COMPONENT_WIDTH),
            .FRACTION_BITS   (FRACTION_BITS),
            .BIT             (FRACTION_BITS - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (s_ctl[k]),
            .i_rem   (s_rem[k]),
            .i_div   (s_div[k]),
            .i_quo   (s_quo[k]),
            .o_ready (s_rdy[k]),
            .i_ready (s_rdy[k+1]),
            .o_ctl   (s_ctl[k+1]),
            .o_rem   (s_rem[k+1]),
            .o_div   (s_div[k+1]),
            .o_quo   (s_quo[k+1])
        );
    end

    // last cell register is the output register
    assign s_rdy[NCELL]   = o_rsp.ready;
    assign o_rsp.valid    = s_ctl[NCELL].valid;
    assign o_rsp.face_out = s_ctl[NCELL].face;
    assign o_rsp.u_coord  = s_quo[NCELL][0];
    assign o_rsp.v_coord  = s_quo[NCELL][1];

`ifndef ASSERT_OFF
    localparam logic [FRACTION_BITS:0] ONE  = (FRACTION_BITS+1)'(1) << FRACTION_BITS;
    localparam logic [FRACTION_BITS:0] HALF = (FRACTION_BITS+1)'(1) << (FRACTION_BITS - 1);

    a_coord_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.u_coord <= ONE && o_rsp.v_coord <= ONE))
        else $error("face coordinate above one");

    a_bad_face_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.face_out > FACE_NZ))
        |-> (o_rsp.u_coord == HALF && o_rsp.v_coord == HALF))
        else $error("invalid face without centered coordinates");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_req.ready |-> (o_rsp.valid && !o_rsp.ready))
        else $error("input stalled while output side free");
`endif

endmodule

// ===== dv/cube_face_and_uv_from_direction_top_tb.sv =====
`timescale 1ns / 1ps

module cube_face_and_uv_from_direction_top_tb;
    import cfu_pkg::*;

    localparam int CW = 16;
    localparam int FB = 15;
    localparam int N_RANDOM = 750;
    localparam int CYCLE_LIMIT = 200000;

    typedef struct {
        logic [2:0]  face;
        logic [FB:0] u;
        logic [FB:0] v;
    } t_uv;

    // face table: major axis, u axis and sign, v axis and sign, looks along +axis
    function automatic void face_layout(input logic [2:0] face, output int major,
                                        output int ua, output int us,
                                        output int va, output int vs, output bit pos);
        case (face)
            FACE_PX: begin major = 0; ua = 2; us = -1; va = 1; vs = -1; pos = 1; end
            FACE_NX: begin major = 0; ua = 2; us = 1;  va = 1; vs = -1; pos = 0; end
            FACE_PY: begin major = 1; ua = 0; us = 1;  va = 2; vs = 1;  pos = 1; end
            FACE_NY: begin major = 1; ua = 0; us = 1;  va = 2; vs = -1; pos = 0; end
            FACE_PZ: begin major = 2; ua = 0; us = 1;  va = 1; vs = -1; pos = 1; end
            default: begin major = 2; ua = 0; us = -1; va = 1; vs = -1; pos = 0; end
        endcase
    endfunction

    // coordinate num/den in [-1,1] mapped to Q1.FB, truncated
    function automatic logic [FB:0] to_q(input longint num, input longint den);
        longint n;
        n = ((num + den) <<< FB) / (2 * den);
        return n[FB:0];
    endfunction

    function automatic t_uv predict_face_uv(input logic func, input logic [2:0] face_in,
                                            input logic signed [CW-1:0] x,
                                            input logic signed [CW-1:0] y,
                                            input logic signed [CW-1:0] z);
        t_uv r;
        longint c[3];
        longint a[3];
        longint un, ud, vn, vd;
        int major, ua, us, va, vs;
        bit pos;
        c[0] = x; c[1] = y; c[2] = z;
        for (int i = 0; i < 3; i++) a[i] = c[i] < 0 ? -c[i] : c[i];
        if (!func) r.face = face_in;
        else if (a[0] > a[1] && a[0] > a[2]) r.face = c[0] > 0 ? FACE_PX : FACE_NX;
        else if (a[1] > a[0] && a[1] > a[2]) r.face = c[1] > 0 ? FACE_PY : FACE_NY;
        else r.face = c[2] > 0 ? FACE_PZ : FACE_NZ;
        if (r.face > FACE_NZ) begin
            r.u = (FB+1)'(1) << (FB - 1);
            r.v = r.u;
            return r;
        end
        face_layout(r.face, major, ua, us, va, vs, pos);
        // a component at least as big as the face axis sits on the edge
        if (a[major] <= a[ua]) begin un = c[ua] > 0 ? us : -us; ud = 1; end
        else begin un = us > 0 ? c[ua] : -c[ua]; ud = a[major]; end
        if (a[major] <= a[va]) begin vn = c[va] > 0 ? vs : -vs; vd = 1; end
        else begin vn = vs > 0 ? c[va] : -c[va]; vd = a[major]; end
        // direction strictly on the opposite face: larger coordinate pinned
        if ((pos ? c[major] < 0 : c[major] > 0) && a[major] > a[ua] && a[major] > a[va]) begin
            if ((un < 0 ? -un : un) > (vn < 0 ? -vn : vn)) begin
                un = un > 0 ? 1 : -1; ud = 1;
            end else begin
                vn = vn > 0 ? 1 : -1; vd = 1;
            end
        end
        r.u = to_q(un, ud);
        r.v = to_q(vn, vd);
        return r;
    endfunction

    class uv_scoreboard;
        t_uv pending[$];
        int  errors;
        int  checked;

        function void note_request(input logic func, input logic [2:0] face,
                                   input logic signed [CW-1:0] x,
                                   input logic signed [CW-1:0] y,
                                   input logic signed [CW-1:0] z);
            pending.push_back(predict_face_uv(func, face, x, y, z));
        endfunction

        function void check_result(input logic [2:0] face, input logic [FB:0] u,
                                   input logic [FB:0] v);
            t_uv e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result face %0d u %0d v %0d", $time, face, u, v);
                errors++;
                return;
            end
            e = pending.pop_front();
            checked++;
            if (face !== e.face) begin
                $display("%0t: face expected %0d actual %0d", $time, e.face, face);
                errors++;
            end
            if (u !== e.u) begin
                $display("%0t: u expected %0d actual %0d", $time, e.u, u);
                errors++;
            end
            if (v !== e.v) begin
                $display("%0t: v expected %0d actual %0d", $time, e.v, v);
                errors++;
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    cfu_in_if #(.COMPONENT_WIDTH(CW)) req_if ();
    cfu_out_if #(.FRACTION_BITS(FB)) rsp_if ();

    uv_scoreboard sb;
    int  cycles;
    int  n_req;
    bit  req_done;

    cube_face_and_uv_from_direction_top #(
        .COMPONENT_WIDTH(CW),
        .FRACTION_BITS  (FB)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    // every accepted request gets a prediction, every accepted result a check
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (i_rst_n && req_if.valid && req_if.ready)
            sb.note_request(req_if.func, req_if.face_in, req_if.dir_x, req_if.dir_y,
                            req_if.dir_z);
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.face_out, rsp_if.u_coord, rsp_if.v_coord);
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("cube_face_and_uv_from_direction_top_tb: done, errors");
            $finish;
        end
    end

    // drive one request: random gap unless no_gap, then hold valid until taken
    task automatic send_request(input logic func, input logic [2:0] face,
                                input logic signed [CW-1:0] x,
                                input logic signed [CW-1:0] y,
                                input logic signed [CW-1:0] z, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid   <= 1'b1;
        req_if.func    <= func;
        req_if.face_in <= face;
        req_if.dir_x   <= x;
        req_if.dir_y   <= y;
        req_if.dir_z   <= z;
        do @(posedge i_clk); while (!req_if.ready);
        @(negedge i_clk);
        n_req++;
    endtask

    // random component, biased toward edges, zero and small magnitudes
    function automatic logic signed [CW-1:0] rand_comp();
        case ($urandom_range(0, 7))
            0: return 16'sh7fff;
            1: return 16'sh8000;
            2: return 16'sd0;
            3: return CW'(int'($urandom_range(0, 8)) - 4);
            default: return CW'($urandom());
        endcase
    endfunction

    // sink side: ready stalls drawn per result, with some stall-free stretches
    initial begin
        int stall;
        bit burst;
        rsp_if.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            burst = ($urandom_range(0, 3) == 0);
            stall = burst ? 0 : $urandom_range(0, 9);
            if (stall > 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
        end
    end

    initial begin
        logic signed [CW-1:0] x, y, z, m;
        bit fast;
        sb = new();
        cycles = 0;
        n_req = 0;
        req_if.valid = 1'b0;
        req_if.func = 1'b0;
        req_if.face_in = '0;
        req_if.dir_x = '0;
        req_if.dir_y = '0;
        req_if.dir_z = '0;
        i_rst_n = 1'b0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: all-zero direction, each given face incl. the invalid ones,
        // extremes, ties between axes, opposite-face directions
        send_request(1'b1, 3'd0, 16'sd0, 16'sd0, 16'sd0, 1'b0);
        for (int f = 0; f < 8; f++)
            send_request(1'b0, f[2:0], 16'sd1000, -16'sd2000, 16'sd3000, 1'b0);
        send_request(1'b1, 3'd7, 16'sh8000, 16'sh7fff, 16'sd5, 1'b0);
        send_request(1'b1, 3'd0, 16'sh7fff, 16'sh8000, 16'sh8000, 1'b0);
        send_request(1'b1, 3'd0, 16'sd100, -16'sd100, 16'sd7, 1'b0);
        send_request(1'b1, 3'd0, 16'sd100, 16'sd100, 16'sd100, 1'b0);
        send_request(1'b1, 3'd0, -16'sd5, 16'sd9, -16'sd9, 1'b0);
        send_request(1'b0, FACE_PX, -16'sd1000, 16'sd300, -16'sd700, 1'b0);
        send_request(1'b0, FACE_NY, 16'sd20, 16'sd900, 16'sd20, 1'b0);
        send_request(1'b0, FACE_PZ, 16'sd50, -16'sd50, -16'sd800, 1'b0);
        send_request(1'b0, FACE_NZ, 16'sh7fff, 16'sh8000, 16'sh7fff, 1'b0);
        send_request(1'b0, FACE_NX, 16'sh8000, 16'sh7fff, 16'sh8000, 1'b0);

        // random: mostly auto picking, some given faces, some all-valid bursts
        fast = 0;
        for (int i = 0; i < N_RANDOM; i++) begin
            if ($urandom_range(0, 15) == 0) fast = !fast;
            x = rand_comp();
            y = rand_comp();
            z = rand_comp();
            if ($urandom_range(0, 3) == 0) begin
                // one axis set to a random nonzero value, the others left random
                m = CW'($urandom_range(1, 32767));
                if ($urandom_range(0, 1)) m = -m;
                case ($urandom_range(0, 2))
                    0: x = m;
                    1: y = m;
                    default: z = m;
                endcase
            end
            send_request($urandom_range(0, 2) != 0, 3'($urandom_range(0, 7)), x, y, z,
                         fast);
        end
        req_if.valid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (FB + 10) @(posedge i_clk);
        $display("sent %0d direction requests, checked %0d face/uv results", n_req,
                 sb.checked);
        $display("covered given and picked faces, invalid faces, ties, axis extremes");
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("cube_face_and_uv_from_direction_top_tb: done, clean");
        else
            $display("cube_face_and_uv_from_direction_top_tb: done, errors");
        $finish;
    end

endmodule
